[design/vgn_pkg.sv]
// Shared types, constants and helper functions of the volume gradient normal encoder.
package vgn_pkg;

    localparam int MAX_DIM  = 64;
    localparam int DIM_W    = $clog2(MAX_DIM);
    localparam int SIZE_W   = 7;
    localparam int PLANE_W  = 2 * DIM_W + 1;
    localparam int ADDR_W   = 3 * DIM_W;
    localparam int DEPTH    = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int VOX_W    = 8;
    localparam int G_W      = 15;
    localparam int GA_W     = 14;
    localparam int SA_W     = 22;
    localparam int S_W      = 28;
    localparam int SQ_W     = 44;
    localparam int MA_W     = 28;
    localparam int MB_W     = 22;
    localparam int P_W      = MA_W + MB_W;
    localparam int CODE_W   = 8;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // neighbor offset codes along one axis
    localparam logic [1:0] OFF_LO  = 2'd0;
    localparam logic [1:0] OFF_MID = 2'd1;
    localparam logic [1:0] OFF_HI  = 2'd2;

    localparam logic [CODE_W-1:0] CODE_ZERO = 8'd128;

    typedef struct packed {
        logic             cmd;
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] z;
        logic [VOX_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [SIZE_W-1:0]  sx;
        logic [SIZE_W-1:0]  sy;
        logic [SIZE_W-1:0]  sz;
        logic [PLANE_W-1:0] plane;
    } t_geom;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_DRAIN,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_SQ_CHK,
        ST_S2_MUL,
        ST_S2_SAVE,
        ST_T_MUL,
        ST_TS_MUL,
        ST_CMP,
        ST_OUT
    } t_state;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        if (s == '0) r = SIZE_W'(1);
        else if (s > SIZE_W'(MAX_DIM)) r = SIZE_W'(MAX_DIM);
        else r = s;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] sat_pos(input logic [DIM_W-1:0] p,
                                                  input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] hi;
        hi = s - SIZE_W'(1);
        return ({1'b0, p} > hi) ? hi[DIM_W-1:0] : p;
    endfunction

    // clamped neighbor coordinate; p is already below s
    function automatic logic [DIM_W-1:0] nb_coord(input logic [DIM_W-1:0] p,
                                                   input logic [1:0] off,
                                                   input logic [SIZE_W-1:0] s);
        logic [DIM_W-1:0] r;
        r = p;
        if (off == OFF_LO) begin
            if (p != '0) r = p - DIM_W'(1);
        end else if (off == OFF_HI) begin
            if ({1'b0, p} != s - SIZE_W'(1)) r = p + DIM_W'(1);
        end
        return r;
    endfunction

    // signed contribution of one voxel to a gradient component
    function automatic logic signed [G_W-1:0] contrib(input logic [VOX_W-1:0] v,
                                                       input logic [1:0] dir,
                                                       input logic [1:0] o1,
                                                       input logic [1:0] o2);
        logic [G_W-1:0] mag;
        logic [2:0]     sh;
        sh  = ((o1 == OFF_MID) ? 3'd2 : 3'd0) + ((o2 == OFF_MID) ? 3'd2 : 3'd0);
        mag = G_W'(v) << sh;
        if (dir == OFF_HI) return $signed(mag);
        else if (dir == OFF_LO) return -$signed(mag);
        else return '0;
    endfunction

endpackage

[design/vgn_front.sv]
// Input stage: takes stream requests, saturates positions to the volume, feeds the queue.
module vgn_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  vgn_pkg::t_item        i_item,
    input  vgn_pkg::t_geom        i_geom,
    output logic                  o_push,
    output vgn_pkg::t_item        o_item,
    input  logic                  i_q_ready
);
    import vgn_pkg::*;

    logic  r_vld;
    t_item r_item;

    assign o_ready = !r_vld || i_q_ready;
    assign o_push  = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.cmd   <= i_item.cmd;
            r_item.x     <= sat_pos(i_item.x, i_geom.sx);
            r_item.y     <= sat_pos(i_item.y, i_geom.sy);
            r_item.z     <= sat_pos(i_item.z, i_geom.sz);
            r_item.value <= i_item.value;
        end
    end

endmodule

[design/vgn_queue.sv]
// Two-entry request queue between the input stage and the gradient engine.
module vgn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vgn_pkg::t_item i_item,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output vgn_pkg::t_item o_item
);
    import vgn_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            if (do_push && !do_pop) r_cnt <= r_cnt + 2'd1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_item;
    end

endmodule

[design/vgn_back.sv]
// Gradient engine: voxel store, neighborhood sweep, exact normal encoding, result register.
module vgn_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vgn_pkg::t_geom                i_geom,
    input  logic                          i_q_valid,
    input  vgn_pkg::t_item                i_q_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [vgn_pkg::CODE_W-1:0]    o_nx,
    output logic [vgn_pkg::CODE_W-1:0]    o_ny,
    output logic [vgn_pkg::CODE_W-1:0]    o_nz,
    output logic [vgn_pkg::VOX_W-1:0]     o_density,
    output logic                          o_flat
);
    import vgn_pkg::*;

    t_state r_state, n_state;
    t_item  r_item;

    logic [VOX_W-1:0] r_vol [DEPTH];
    logic [VOX_W-1:0] r_rdata;

    logic [1:0] r_ox, r_oy, r_oz;
    logic       r_rd_vld;
    logic [1:0] r_rd_ox, r_rd_oy, r_rd_oz;

    logic signed [G_W-1:0] r_gx, r_gy, r_gz;
    logic [S_W-1:0]        r_s;
    logic [SQ_W-1:0]       r_s2;
    logic [P_W-1:0]        r_prod;
    logic [1:0]            r_k;
    logic [2:0]            r_bit;
    logic [CODE_W-1:0]     r_code;
    logic [CODE_W-1:0]     r_nx, r_ny, r_nz;
    logic [VOX_W-1:0]      r_dens;
    logic                  r_flat;

    logic                  r_out_vld;
    logic [CODE_W-1:0]     r_out_nx, r_out_ny, r_out_nz;
    logic [VOX_W-1:0]      r_out_dens;
    logic                  r_out_flat;

    logic [ADDR_W-1:0]     addr;
    logic [DIM_W-1:0]      cx, cy, cz;
    logic                  mem_we;
    logic                  out_free;
    logic                  out_load;
    logic [MA_W-1:0]       mul_a;
    logic [MB_W-1:0]       mul_b;
    logic signed [G_W-1:0] g_sel;
    logic [GA_W-1:0]       g_abs;
    logic [SA_W-1:0]       s_abs;
    logic [CODE_W-1:0]     cand;
    logic [CODE_W-1:0]     t_abs;
    logic                  t_neg, t_zero, s_neg, pass;
    logic                  last_off;

    // ---------------- address and store ----------------
    assign cx   = nb_coord(r_item.x, r_ox, i_geom.sx);
    assign cy   = nb_coord(r_item.y, r_oy, i_geom.sy);
    assign cz   = nb_coord(r_item.z, r_oz, i_geom.sz);
    assign addr = ADDR_W'(cz) * ADDR_W'(i_geom.plane) + ADDR_W'(cy) * ADDR_W'(i_geom.sx)
                + ADDR_W'(cx);

    always_ff @(posedge i_clk) begin
        if (mem_we) r_vol[addr] <= r_item.value;
        r_rdata <= r_vol[addr];
    end

    // ---------------- component select and encode terms ----------------
    always_comb begin
        unique case (r_k)
            2'd0:    g_sel = r_gx;
            2'd1:    g_sel = r_gy;
            default: g_sel = r_gz;
        endcase
    end

    assign g_abs    = g_sel[G_W-1] ? GA_W'(-g_sel) : GA_W'(g_sel);
    assign s_abs    = (SA_W'(g_abs) << 8) - SA_W'(g_abs);
    assign cand     = r_code | (CODE_W'(1) << r_bit);
    assign t_neg    = (cand < CODE_ZERO);
    assign t_zero   = (cand == CODE_ZERO);
    assign t_abs    = t_neg ? CODE_W'((CODE_ZERO - cand) << 1) : CODE_W'((cand - CODE_ZERO) << 1);
    assign s_neg    = g_sel[G_W-1];
    assign last_off = (r_ox == OFF_HI) && (r_oy == OFF_HI) && (r_oz == OFF_HI);
    assign out_free = !r_out_vld || i_ready;

    // t*sqrt(S) <= s, decided on squares
    always_comb begin
        priority if ((t_neg || t_zero) && !s_neg) pass = 1'b1;
        else if (!t_neg && s_neg)                 pass = 1'b0;
        else if (!t_neg)                          pass = (r_prod[SQ_W-1:0] <= r_s2);
        else                                      pass = (r_prod[SQ_W-1:0] >= r_s2);
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) n_state = (i_q_item.cmd == CMD_LOAD) ? ST_LOAD : ST_READ;
            end
            ST_LOAD:    n_state = ST_IDLE;
            ST_READ:    if (last_off) n_state = ST_DRAIN;
            ST_DRAIN:   n_state = ST_SQ_MUL;
            ST_SQ_MUL:  n_state = ST_SQ_ADD;
            ST_SQ_ADD:  n_state = (r_k == 2'd2) ? ST_SQ_CHK : ST_SQ_MUL;
            ST_SQ_CHK:  n_state = (r_s == '0) ? ST_OUT : ST_S2_MUL;
            ST_S2_MUL:  n_state = ST_S2_SAVE;
            ST_S2_SAVE: n_state = ST_T_MUL;
            ST_T_MUL:   n_state = ST_TS_MUL;
            ST_TS_MUL:  n_state = ST_CMP;
            ST_CMP: begin
                if (r_bit != 3'd0) n_state = ST_T_MUL;
                else if (r_k == 2'd2) n_state = ST_OUT;
                else n_state = ST_S2_MUL;
            end
            ST_OUT:     if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (r_state)
            ST_IDLE:   o_pop = i_q_valid;
            ST_LOAD:   mem_we = 1'b1;
            ST_SQ_MUL: begin
                mul_a = MA_W'(g_abs);
                mul_b = MB_W'(g_abs);
            end
            ST_S2_MUL: begin
                mul_a = MA_W'(s_abs);
                mul_b = s_abs;
            end
            ST_T_MUL: begin
                mul_a = MA_W'(t_abs);
                mul_b = MB_W'(t_abs);
            end
            ST_TS_MUL: begin
                mul_a = r_s;
                mul_b = MB_W'(r_prod[2*CODE_W-1:0]);
            end
            ST_OUT:    out_load = out_free;
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_READ);
            if (out_load) r_out_vld <= 1'b1;
            else if (i_ready) r_out_vld <= 1'b0;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        r_prod  <= P_W'(mul_a) * P_W'(mul_b);
        r_rd_ox <= r_ox;
        r_rd_oy <= r_oy;
        r_rd_oz <= r_oz;

        if (r_rd_vld) begin
            r_gx <= r_gx + contrib(r_rdata, r_rd_ox, r_rd_oy, r_rd_oz);
            r_gy <= r_gy + contrib(r_rdata, r_rd_oy, r_rd_ox, r_rd_oz);
            r_gz <= r_gz + contrib(r_rdata, r_rd_oz, r_rd_ox, r_rd_oy);
            if (r_rd_ox == OFF_MID && r_rd_oy == OFF_MID && r_rd_oz == OFF_MID)
                r_dens <= r_rdata;
        end

        unique case (r_state)
            ST_IDLE: begin
                r_item <= i_q_item;
                r_gx   <= '0;
                r_gy   <= '0;
                r_gz   <= '0;
                r_s    <= '0;
                r_k    <= 2'd0;
                if (i_q_item.cmd == CMD_LOAD) begin
                    r_ox <= OFF_MID;
                    r_oy <= OFF_MID;
                    r_oz <= OFF_MID;
                end else begin
                    r_ox <= OFF_LO;
                    r_oy <= OFF_LO;
                    r_oz <= OFF_LO;
                end
            end
            ST_READ: begin
                if (r_ox != OFF_HI) begin
                    r_ox <= r_ox + 2'd1;
                end else begin
                    r_ox <= OFF_LO;
                    if (r_oy != OFF_HI) begin
                        r_oy <= r_oy + 2'd1;
                    end else begin
                        r_oy <= OFF_LO;
                        r_oz <= r_oz + 2'd1;
                    end
                end
            end
            ST_SQ_ADD: begin
                r_s <= r_s + r_prod[S_W-1:0];
                r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            ST_SQ_CHK: begin
                r_flat <= (r_s == '0);
                r_nx   <= CODE_ZERO;
                r_ny   <= CODE_ZERO;
                r_nz   <= CODE_ZERO;
            end
            ST_S2_SAVE: begin
                r_s2   <= r_prod[SQ_W-1:0];
                r_code <= '0;
                r_bit  <= 3'd7;
            end
            ST_CMP: begin
                if (pass) r_code <= cand;
                if (r_bit != 3'd0) begin
                    r_bit <= r_bit - 3'd1;
                end else begin
                    unique case (r_k)
                        2'd0:    r_nx <= pass ? cand : r_code;
                        2'd1:    r_ny <= pass ? cand : r_code;
                        default: r_nz <= pass ? cand : r_code;
                    endcase
                    r_k <= r_k + 2'd1;
                end
            end
            default: ;
        endcase

        if (out_load) begin
            r_out_nx   <= r_nx;
            r_out_ny   <= r_ny;
            r_out_nz   <= r_nz;
            r_out_dens <= r_dens;
            r_out_flat <= r_flat;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_nx      = r_out_nx;
    assign o_ny      = r_out_ny;
    assign o_nz      = r_out_nz;
    assign o_density = r_out_dens;
    assign o_flat    = r_out_flat;

`ifndef SYNTH
    a_search_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_T_MUL || r_state == ST_CMP) |-> (r_s != '0))
        else $error("normal search running on a zero gradient");

    a_read_follows_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state == ST_READ))
        else $error("read data flagged outside the neighborhood sweep");

    a_flat_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_flat) |->
            (r_nx == CODE_ZERO && r_ny == CODE_ZERO && r_nz == CODE_ZERO))
        else $error("flat result with non-center codes");

    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_rd_ox == OFF_HI && r_rd_oy == OFF_HI && r_rd_oz == OFF_HI))
        else $error("sweep ended before the last neighbor");
`endif

endmodule

[design/volume_gradient_normal_encoder.sv]
// Top level of the volume gradient normal encoder: configuration, input stage, queue, engine.
//
// A 64x64x64 byte volume sits in a single-port on-chip store laid out as
// z*size_x*size_y + y*size_x + x. A request with tuser = 0 writes one voxel and
// returns nothing; a request with tuser = 1 returns the encoded unit gradient at
// a voxel together with its density. Positions beyond a configured extent are
// saturated to the last voxel. The gradient is the central difference along each
// axis weighted 1,4,1 across the other two, with edge clamping; each normal
// component is floor(127.5*n + 128) decided by exact integer compares, and a zero
// gradient gives 128,128,128 with tuser flat set. A query makes 27 store reads
// (one per cycle through the single read port), forms |g|^2, then per component
// runs an 8-step bit search through one shared multiplier. The input stage and
// a two-entry queue keep taking requests while the engine is busy; a finished
// result waits in the output register while the engine starts the next request,
// and the engine holds its next result until that register is free. Sizes are
// written over the config channel (index 0 x, 1 y, 2 z) while the block is idle;
// the store is not cleared on reset or size change and voxels must be written
// before they are queried.
module volume_gradient_normal_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // pos_x[5:0] pos_y[11:6] pos_z[17:12] voxel_value[25:18]
    input  logic [0:0]  i_s_axis_tuser,   // cmd[0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // normal_x[7:0] normal_y[15:8] normal_z[23:16] density[31:24]
    output logic [0:0]  o_m_axis_tuser    // flat[0]
);
    import vgn_pkg::*;

    logic [SIZE_W-1:0]  r_size_x, r_size_y, r_size_z;
    logic [PLANE_W-1:0] r_plane;
    t_geom              geom;
    t_item              in_item;
    t_item              f_item;
    t_item              q_item;
    logic               f_push, q_ready, q_valid, q_pop;
    logic [CODE_W-1:0]  nx, ny, nz;
    logic [VOX_W-1:0]   dens;
    logic               flat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_W'(MAX_DIM);
            r_size_y <= SIZE_W'(MAX_DIM);
            r_size_z <= SIZE_W'(MAX_DIM);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes, plus the z stride kept in a register
    assign geom.sx    = eff_size(r_size_x);
    assign geom.sy    = eff_size(r_size_y);
    assign geom.sz    = eff_size(r_size_z);
    assign geom.plane = r_plane;

    always_ff @(posedge i_clk) begin
        r_plane <= PLANE_W'(geom.sx) * PLANE_W'(geom.sy);
    end

    assign in_item.cmd   = i_s_axis_tuser[0];
    assign in_item.x     = i_s_axis_tdata[5:0];
    assign in_item.y     = i_s_axis_tdata[11:6];
    assign in_item.z     = i_s_axis_tdata[17:12];
    assign in_item.value = i_s_axis_tdata[25:18];

    vgn_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .i_geom    (geom),
        .o_push    (f_push),
        .o_item    (f_item),
        .i_q_ready (q_ready)
    );

    vgn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    vgn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_nx      (nx),
        .o_ny      (ny),
        .o_nz      (nz),
        .o_density (dens),
        .o_flat    (flat)
    );

    assign o_m_axis_tdata = {dens, nz, ny, nx};
    assign o_m_axis_tuser = flat;

endmodule

[test/volume_gradient_normal_encoder_check.sv]
`timescale 1ns / 100ps
// Checker for the volume gradient normal encoder: shadow volume, gradient predictor, compare.
module volume_gradient_normal_encoder_check
    import vgn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,
    input  logic [0:0]  i_req_user,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_data,
    input  logic [0:0]  i_res_user,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] nx;
        logic [7:0] ny;
        logic [7:0] nz;
        logic [7:0] density;
        logic       flat;
    } t_normal;

    logic [7:0]     shadow_vol [0:DEPTH-1];
    logic [6:0]     ext_x, ext_y, ext_z;
    t_normal        normal_q [$];

    assign o_pending = normal_q.size();

    function automatic int eff_dim(input logic [6:0] s);
        if (s == 0) return 1;
        if (s > MAX_DIM) return MAX_DIM;
        return s;
    endfunction

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int voxel(input int x, input int y, input int z);
        int sx, sy, sz;
        sx = eff_dim(ext_x);
        sy = eff_dim(ext_y);
        sz = eff_dim(ext_z);
        return shadow_vol[clamp_dim(z, sz - 1) * sx * sy + clamp_dim(y, sy - 1) * sx
                          + clamp_dim(x, sx - 1)];
    endfunction

    // exact test of t*sqrt(s) <= n
    function automatic bit scaled_le(input longint t, input longint n, input longint s);
        if (t <= 0 && n >= 0) return 1;
        if (t >= 0 && n < 0) return 0;
        if (t > 0) return t * t * s <= n * n;
        return t * t * s >= n * n;
    endfunction

    function automatic logic [7:0] encode_axis(input longint num, input longint s);
        for (int c = 255; c > 0; c--)
            if (scaled_le(2 * (c - 128), 255 * num, s)) return 8'(c);
        return 8'd0;
    endfunction

    function automatic t_normal predict_normal(input int x, input int y, input int z);
        int      wgt [3];
        int      gx, gy, gz, wt;
        longint  s;
        t_normal r;
        wgt = '{1, 4, 1};
        gx = 0;
        gy = 0;
        gz = 0;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++) begin
                wt = wgt[a] * wgt[b];
                gx += wt * (voxel(x + 1, y + a - 1, z + b - 1) - voxel(x - 1, y + a - 1, z + b - 1));
                gy += wt * (voxel(x + a - 1, y + 1, z + b - 1) - voxel(x + a - 1, y - 1, z + b - 1));
                gz += wt * (voxel(x + a - 1, y + b - 1, z + 1) - voxel(x + a - 1, y + b - 1, z - 1));
            end
        s = longint'(gx) * gx + longint'(gy) * gy + longint'(gz) * gz;
        if (s == 0) begin
            r.nx = CODE_ZERO;
            r.ny = CODE_ZERO;
            r.nz = CODE_ZERO;
            r.flat = 1'b1;
        end else begin
            r.nx = encode_axis(gx, s);
            r.ny = encode_axis(gy, s);
            r.nz = encode_axis(gz, s);
            r.flat = 1'b0;
        end
        r.density = 8'(voxel(x, y, z));
        return r;
    endfunction

    always @(posedge i_clk) begin
        int      x, y, z, sx, sy, sz;
        t_normal got, exp_n;
        if (!i_rst_n) begin
            ext_x <= 7'd64;
            ext_y <= 7'd64;
            ext_z <= 7'd64;
            o_fail_count <= 0;
            normal_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SIZE_X: ext_x <= i_cfg_data;
                    CFG_SIZE_Y: ext_y <= i_cfg_data;
                    CFG_SIZE_Z: ext_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                sx = eff_dim(ext_x);
                sy = eff_dim(ext_y);
                sz = eff_dim(ext_z);
                x = clamp_dim(i_req_data[5:0], sx - 1);
                y = clamp_dim(i_req_data[11:6], sy - 1);
                z = clamp_dim(i_req_data[17:12], sz - 1);
                if (i_req_user[0] == CMD_LOAD)
                    shadow_vol[z * sx * sy + y * sx + x] = i_req_data[25:18];
                else
                    normal_q.push_back(predict_normal(x, y, z));
            end
            if (i_res_valid && i_res_ready) begin
                got = {i_res_data[7:0], i_res_data[15:8], i_res_data[23:16],
                       i_res_data[31:24], i_res_user[0]};
                if (normal_q.size() == 0) begin
                    $error("unexpected result %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_n = normal_q.pop_front();
                    if (got != exp_n) begin
                        if (got.nx != exp_n.nx)
                            $error("normal_x expected %0d got %0d", exp_n.nx, got.nx);
                        if (got.ny != exp_n.ny)
                            $error("normal_y expected %0d got %0d", exp_n.ny, got.ny);
                        if (got.nz != exp_n.nz)
                            $error("normal_z expected %0d got %0d", exp_n.nz, got.nz);
                        if (got.density != exp_n.density)
                            $error("density expected %0d got %0d", exp_n.density, got.density);
                        if (got.flat != exp_n.flat)
                            $error("flat expected %0d got %0d", exp_n.flat, got.flat);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[test/volume_gradient_normal_encoder_test.sv]
`timescale 1ns / 100ps
// Testbench top of the volume gradient normal encoder: stimulus, watchdog and verdict.
module volume_gradient_normal_encoder_test;
    import vgn_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [31:0] req_data = '0;
    logic [0:0]  req_user = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [31:0] res_data;
    logic [0:0]  res_user;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          ready_always = 0;
    int          stall_mode_left = 0;
    // addresses loaded at least once; queries only run over fully loaded layouts
    bit          loaded [0:DEPTH-1];
    int          dim_x, dim_y, dim_z;

    always #6 i_clk = ~i_clk;

    volume_gradient_normal_encoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_user),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tuser  (res_user)
    );

    volume_gradient_normal_encoder_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req_data   (req_data),
        .i_req_user   (req_user),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_data   (res_data),
        .i_res_user   (res_user),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: alternates stretches of always-ready with random stalls
    always @(posedge i_clk) begin
        if (stall_mode_left == 0) begin
            ready_always = $urandom_range(0, 2) == 0;
            stall_mode_left = $urandom_range(20, 400);
        end else begin
            stall_mode_left--;
        end
        res_ready <= ready_always ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // watchdog: cycles without any accepted request, result or config write
    always @(posedge i_clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one request, sent in bursts with random gaps in between
    task automatic send_req(input logic cmd, input int x, input int y, input int z,
                            input int v);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_valid <= 1'b1;
        req_user  <= cmd;
        req_data  <= {6'd0, 8'(v), 6'(z), 6'(y), 6'(x)};
        do @(posedge i_clk); while (!req_ready);
        if (cmd == CMD_LOAD)
            loaded[(z > dim_z - 1 ? dim_z - 1 : z) * dim_x * dim_y
                   + (y > dim_y - 1 ? dim_y - 1 : y) * dim_x
                   + (x > dim_x - 1 ? dim_x - 1 : x)] = 1'b1;
    endtask

    // waits out every pending result plus the engine latency of trailing loads
    task automatic wait_idle();
        req_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // new extents, then every voxel of the new layout that was never loaded
    task automatic set_extent(input logic [6:0] sx, input logic [6:0] sy,
                              input logic [6:0] sz);
        wait_idle();
        write_reg(CFG_SIZE_X, sx);
        write_reg(CFG_SIZE_Y, sy);
        write_reg(CFG_SIZE_Z, sz);
        dim_x = sx == 0 ? 1 : (sx > MAX_DIM ? MAX_DIM : sx);
        dim_y = sy == 0 ? 1 : (sy > MAX_DIM ? MAX_DIM : sy);
        dim_z = sz == 0 ? 1 : (sz > MAX_DIM ? MAX_DIM : sz);
        for (int z = 0; z < dim_z; z++)
            for (int y = 0; y < dim_y; y++)
                for (int x = 0; x < dim_x; x++)
                    if (!loaded[z * dim_x * dim_y + y * dim_x + x])
                        send_req(CMD_LOAD, x, y, z, $urandom_range(0, 255));
    endtask

    // mixed random loads and queries over the whole coordinate range
    task automatic random_mix(input int count);
        int v;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: v = 0;
                1: v = 255;
                default: v = $urandom_range(0, 255);
            endcase
            if ($urandom_range(0, 2) == 0)
                send_req(CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 63), v);
            else
                send_req(CMD_QUERY, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 63), v);
        end
    endtask

    initial begin
        dim_x = MAX_DIM;
        dim_y = MAX_DIM;
        dim_z = MAX_DIM;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: a uniform 4x4x4 block is flat everywhere
        set_extent(7'd4, 7'd4, 7'd4);
        for (int i = 0; i < 64; i++)
            send_req(CMD_LOAD, i % 4, (i / 4) % 4, i / 16, 255);
        send_req(CMD_QUERY, 0, 0, 0, 0);
        send_req(CMD_QUERY, 63, 63, 63, 255);
        // two dark corners: steep gradients at the edges, saturated load position
        send_req(CMD_LOAD, 63, 63, 63, 0);
        send_req(CMD_QUERY, 3, 3, 3, 0);
        send_req(CMD_QUERY, 2, 3, 3, 0);
        send_req(CMD_QUERY, 3, 2, 2, 0);
        send_req(CMD_LOAD, 0, 0, 0, 0);
        send_req(CMD_QUERY, 0, 0, 0, 0);
        send_req(CMD_QUERY, 1, 0, 0, 0);
        send_req(CMD_QUERY, 1, 1, 1, 0);
        send_req(CMD_QUERY, 0, 1, 0, 0);
        send_req(CMD_QUERY, 0, 0, 1, 0);
        random_mix(60);

        // extremes: one long axis, a zero size, an oversized size
        set_extent(7'd64, 7'd1, 7'd1);
        random_mix(50);
        set_extent(7'd1, 7'd64, 7'd1);
        random_mix(50);
        set_extent(7'd0, 7'd1, 7'd127);
        random_mix(50);
        set_extent(7'd127, 7'd2, 7'd0);
        random_mix(50);
        // old voxels read through new layouts
        set_extent(7'd3, 7'd5, 7'd2);
        random_mix(50);
        set_extent(7'd8, 7'd8, 7'd8);
        random_mix(80);
        set_extent(7'd2, 7'd2, 7'd2);
        random_mix(40);

        req_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
